[rtl/sqct_pkg.sv]
package sqct_pkg;

    localparam int CS_W     = 18;
    localparam int QDEPTH   = 2;
    localparam int IN_DW    = 152;
    localparam int IN_UW    = 4;
    localparam int OUT_DW   = 80;

    localparam logic KIND_RECT   = 1'b0;
    localparam logic KIND_CIRCLE = 1'b1;

    localparam logic signed [18:0] CORDIC_SEED = 19'sd19898;
    localparam logic [15:0] RECIP_255 = 16'd32897;

    typedef struct packed {
        logic        kind;
        logic        visible;
        logic        first_scene;
        logic        clr_opaque;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] angle;
        logic [23:0] top_rgb;
        logic [23:0] bot_rgb;
        logic [16:0] top_ax;
        logic [16:0] bot_ax;
    } sqct_entry_t;

    typedef struct packed {
        logic        start;
        logic [15:0] angle;
    } sqct_cordic_req_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ANG  = 8'b0000_0010,
        ST_SEG  = 8'b0000_0100,
        ST_MUL1 = 8'b0000_1000,
        ST_SUM  = 8'b0001_0000,
        ST_MUL2 = 8'b0010_0000,
        ST_FIN  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } sqct_state_t;

    function automatic logic [13:0] cordic_atan(input logic [3:0] i);
        logic [13:0] r;
        unique case (i)
            4'd0:    r = 14'd8192;
            4'd1:    r = 14'd4836;
            4'd2:    r = 14'd2555;
            4'd3:    r = 14'd1297;
            4'd4:    r = 14'd651;
            4'd5:    r = 14'd326;
            4'd6:    r = 14'd163;
            4'd7:    r = 14'd81;
            4'd8:    r = 14'd41;
            4'd9:    r = 14'd20;
            4'd10:   r = 14'd10;
            4'd11:   r = 14'd5;
            4'd12:   r = 14'd3;
            4'd13:   r = 14'd1;
            4'd14:   r = 14'd1;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/sprite_quad_circle_tessellator_top.sv]
// channel | dir | tdata (low bit up)                                   | tuser / tlast
// s_      | in  | center_x, center_y, size_w, size_h, angle, top_rgba,  | tuser: kind, visible,
//         |     | bottom_rgba, opacity (152 bits)                      |   background, first_of_scene
// m_      | out | vx, vy, red, green, blue, alpha, vertex_index, pad   | tuser: background_opaque;
//         |     | (80 bits)                                            |   tlast: last
// A 15-step CORDIC gives the element angle and, for a circle, each segment angle;
// every vertex passes through the two-stage multiplier path.
// A hidden element is dequeued with no CORDIC run and no vertex output.
// Reset clears the request queue, vertex counter (0) and opaque flag (1).
// A stalled m_ side holds the back end; the 2-deep queue keeps taking requests until it is full.
module sprite_quad_circle_tessellator_top #(
    parameter int SEGMENTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sqct_pkg::IN_DW-1:0]    s_tdata,   // center_x,center_y,size_w,size_h,angle,top,bottom,opacity
    input  logic [sqct_pkg::IN_UW-1:0]    s_tuser,   // kind,visible,background,first_of_scene
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sqct_pkg::OUT_DW-1:0]   m_tdata,   // vx,vy,red,green,blue,alpha,vertex_index
    output logic                          m_tuser,   // background_opaque
    output logic                          m_tlast
);
    import sqct_pkg::*;

    sqct_entry_t            fe_entry;
    sqct_entry_t            q_head;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    sqct_cordic_req_t       creq;
    logic                   cdone;
    logic signed [CS_W-1:0] ccos;
    logic signed [CS_W-1:0] csin;

    assign s_tready = !q_full;

    sqct_front u_front (
        .in_user (s_tuser),
        .in_data (s_tdata),
        .entry   (fe_entry)
    );

    sqct_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_tvalid && s_tready),
        .din     (fe_entry),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_head),
        .empty   (q_empty)
    );

    sqct_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .done    (cdone),
        .cos_o   (ccos),
        .sin_o   (csin)
    );

    sqct_back #(.SEGMENTS(SEGMENTS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .creq     (creq),
        .cdone    (cdone),
        .cos_i    (ccos),
        .sin_i    (csin),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/sqct_front.sv]
module sqct_front (
    input  logic [sqct_pkg::IN_UW-1:0] in_user,
    input  logic [sqct_pkg::IN_DW-1:0] in_data,
    output sqct_pkg::sqct_entry_t      entry
);
    import sqct_pkg::*;

    logic [31:0] top;
    logic [31:0] bot;
    logic [7:0]  opac;
    logic [15:0] top_prod;
    logic [15:0] bot_prod;

    assign top  = in_data[111:80];
    assign bot  = in_data[143:112];
    assign opac = in_data[151:144];

    assign top_prod = top[7:0] * opac;
    assign bot_prod = bot[7:0] * opac;

    always_comb begin
        entry.kind        = in_user[0];
        entry.visible     = in_user[1];
        entry.first_scene = in_user[3];
        entry.clr_opaque  = in_user[2] &
                            ((top[7:0] != 8'hFF) || (bot[7:0] != 8'hFF) || (opac != 8'hFF));
        entry.cx          = in_data[15:0];
        entry.cy          = in_data[31:16];
        entry.w           = in_data[47:32];
        entry.h           = in_data[63:48];
        entry.angle       = in_data[79:64];
        entry.top_rgb     = top[31:8];
        entry.bot_rgb     = bot[31:8];
        entry.top_ax      = {1'b0, top_prod} + 17'd127;
        entry.bot_ax      = {1'b0, bot_prod} + 17'd127;
    end

endmodule

[rtl/sqct_queue.sv]
module sqct_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  sqct_pkg::sqct_entry_t din,
    output logic                  full,
    input  logic                  pop,
    output sqct_pkg::sqct_entry_t dout,
    output logic                  empty
);
    import sqct_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    sqct_entry_t   mem_reg [QDEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == CW'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= din;
        end
    end

endmodule

[rtl/sqct_cordic.sv]
module sqct_cordic (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sqct_pkg::sqct_cordic_req_t          req,
    output logic                                done,
    output logic signed [sqct_pkg::CS_W-1:0]    cos_o,
    output logic signed [sqct_pkg::CS_W-1:0]    sin_o
);
    import sqct_pkg::*;

    logic signed [18:0] x_reg;
    logic signed [18:0] y_reg;
    logic signed [16:0] z_reg;
    logic [1:0]         q_reg;
    logic [3:0]         i_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [18:0] xs;
    logic signed [18:0] ys;
    logic signed [16:0] at;
    logic signed [18:0] nx;
    logic signed [18:0] ny;

    assign xs   = x_reg >>> i_reg;
    assign ys   = y_reg >>> i_reg;
    assign at   = $signed({3'b000, cordic_atan(i_reg)});
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end else if (busy_reg) begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == 4'd14) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg <= CORDIC_SEED;
            y_reg <= '0;
            z_reg <= $signed({3'b000, req.angle[13:0]});
            q_reg <= req.angle[15:14];
        end else if (busy_reg) begin
            if (!z_reg[16]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    always_comb begin
        unique case (q_reg)
            2'd0: begin nx = x_reg;  ny = y_reg;  end
            2'd1: begin nx = -y_reg; ny = x_reg;  end
            2'd2: begin nx = -x_reg; ny = -y_reg; end
            default: begin nx = y_reg; ny = -x_reg; end
        endcase
        cos_o = nx[CS_W-1:0];
        sin_o = ny[CS_W-1:0];
    end

endmodule

[rtl/sqct_back.sv]
module sqct_back #(
    parameter int SEGMENTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sqct_pkg::sqct_entry_t             head,
    input  logic                              empty,
    output logic                              pop,
    output sqct_pkg::sqct_cordic_req_t        creq,
    input  logic                              cdone,
    input  logic signed [sqct_pkg::CS_W-1:0]  cos_i,
    input  logic signed [sqct_pkg::CS_W-1:0]  sin_i,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sqct_pkg::OUT_DW-1:0]       m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import sqct_pkg::*;

    localparam int SEG_Q = 65536 / SEGMENTS;
    localparam int SEG_R = 65536 % SEGMENTS;
    localparam int RW    = $clog2(2 * SEGMENTS);
    localparam int KW    = $clog2(SEGMENTS);

    sqct_state_t state_reg, state_next;

    logic [11:0]              cnt_reg;
    logic                     opq_reg;
    logic                     mvalid_reg;
    logic                     cstart_reg;
    logic [15:0]              cang_reg;

    logic                     kind_reg;
    logic [15:0]              cx_reg, cy_reg, w_reg, h_reg;
    logic [23:0]              top_reg, bot_reg;
    logic [7:0]               atop_reg, abot_reg;
    logic signed [CS_W-1:0]   c_reg, s_reg, c0_reg, s0_reg, c1_reg, s1_reg;
    logic [KW-1:0]            seg_reg;
    logic [16:0]              aq_reg;
    logic [RW-1:0]            ar_reg;
    logic                     segfirst_reg;
    logic [2:0]               vsel_reg;
    logic signed [35:0]       t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [36:0]       ex_reg, ey_reg;
    logic signed [35:0]       m1x_reg, m2x_reg, m1y_reg, m2y_reg;
    logic [OUT_DW-1:0]        tdata_reg;
    logic                     tuser_reg;
    logic                     tlast_reg;

    logic signed [CS_W-1:0]   p, q;
    logic signed [16:0]       mval;
    logic                     use_bot;
    logic                     vlast;
    logic signed [CS_W-1:0]   wpos, wneg, hpos, hneg;
    logic [RW:0]              rsum;
    logic [16:0]              aq_adv;
    logic [RW-1:0]            ar_adv;
    logic [32:0]              ptop, pbot;
    logic                     opq_first;
    logic [15:0]              vx, vy;
    logic [23:0]              rgb;

    function automatic logic [15:0] place(input logic signed [35:0] m1,
                                          input logic signed [35:0] m2,
                                          input logic [15:0] ctr);
        logic signed [55:0] d;
        logic signed [55:0] dr;
        logic signed [26:0] sum;
        d   = (56'(m1) <<< 18) + 56'(m2);
        dr  = (d + 56'sd1073741824) >>> 31;
        sum = 27'($signed(dr[24:0])) + 27'($signed(ctr));
        if (sum > 27'sd32767) begin
            return 16'h7FFF;
        end else if (sum < -27'sd32768) begin
            return 16'h8000;
        end
        return sum[15:0];
    endfunction

    assign wpos = $signed({2'b00, w_reg});
    assign wneg = -wpos;
    assign hpos = $signed({2'b00, h_reg});
    assign hneg = -hpos;

    always_comb begin
        p       = '0;
        q       = '0;
        use_bot = 1'b0;
        vlast   = 1'b0;
        if (kind_reg == KIND_RECT) begin
            mval = 17'sd32768;
            unique case (vsel_reg)
                3'd1: begin p = wpos; q = hneg; end
                3'd2: begin p = wpos; q = hpos; use_bot = 1'b1; end
                3'd3: begin p = wneg; q = hneg; end
                3'd4: begin p = wpos; q = hpos; use_bot = 1'b1; end
                3'd5: begin p = wneg; q = hpos; use_bot = 1'b1; vlast = 1'b1; end
                default: begin p = wneg; q = hneg; end
            endcase
        end else begin
            mval = $signed({1'b0, w_reg});
            unique case (vsel_reg)
                3'd1: begin p = c0_reg; q = s0_reg; end
                3'd2: begin
                    p = c1_reg; q = s1_reg;
                    vlast = (seg_reg == KW'(SEGMENTS - 1));
                end
                default: begin p = '0; q = '0; end
            endcase
        end
    end

    // next segment angle: round(k*65536/SEGMENTS) by quotient/remainder stepping
    always_comb begin
        rsum = {1'b0, ar_reg} + (RW + 1)'(SEG_R);
        if (rsum >= (RW + 1)'(SEGMENTS)) begin
            aq_adv = aq_reg + 17'(SEG_Q) + 17'd1;
            ar_adv = RW'(rsum - (RW + 1)'(SEGMENTS));
        end else begin
            aq_adv = aq_reg + 17'(SEG_Q);
            ar_adv = rsum[RW-1:0];
        end
    end

    assign ptop = {16'b0, head.top_ax} * {17'b0, RECIP_255};
    assign pbot = {16'b0, head.bot_ax} * {17'b0, RECIP_255};
    assign opq_first = head.first_scene ? 1'b1 : opq_reg;

    assign vx  = place(m1x_reg, m2x_reg, cx_reg);
    assign vy  = place(m1y_reg, m2y_reg, cy_reg);
    assign rgb = use_bot ? bot_reg : top_reg;

    assign pop        = (state_reg == ST_IDLE) && !empty;
    assign creq.start = cstart_reg;
    assign creq.angle = cang_reg;
    assign m_tvalid   = mvalid_reg;
    assign m_tdata    = tdata_reg;
    assign m_tuser    = tuser_reg;
    assign m_tlast    = tlast_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!empty && head.visible) state_next = ST_ANG;
            ST_ANG:  if (cdone) state_next = (kind_reg == KIND_CIRCLE) ? ST_SEG : ST_MUL1;
            ST_SEG:  if (cdone && !segfirst_reg) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_SUM;
            ST_SUM:  state_next = ST_MUL2;
            ST_MUL2: state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) begin
                    if (vlast) begin
                        state_next = ST_IDLE;
                    end else if (kind_reg == KIND_CIRCLE && vsel_reg == 3'd2) begin
                        state_next = ST_SEG;
                    end else begin
                        state_next = ST_MUL1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            opq_reg    <= 1'b1;
            mvalid_reg <= 1'b0;
            cstart_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cstart_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (!empty) begin
                        if (head.first_scene) begin
                            cnt_reg <= '0;
                        end
                        opq_reg <= head.visible ? (opq_first & ~head.clr_opaque) : opq_first;
                        if (head.visible) begin
                            cstart_reg <= 1'b1;
                        end
                    end
                end
                ST_ANG: begin
                    if (cdone && kind_reg == KIND_CIRCLE) begin
                        cstart_reg <= 1'b1;
                    end
                end
                ST_SEG: begin
                    if (cdone && segfirst_reg) begin
                        cstart_reg <= 1'b1;
                    end
                end
                ST_FIN: begin
                    mvalid_reg <= 1'b1;
                    cnt_reg    <= cnt_reg + 1'b1;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        mvalid_reg <= 1'b0;
                        if (!vlast && kind_reg == KIND_CIRCLE && vsel_reg == 3'd2) begin
                            cstart_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                kind_reg <= head.kind;
                cx_reg   <= head.cx;
                cy_reg   <= head.cy;
                w_reg    <= head.w;
                h_reg    <= head.h;
                top_reg  <= head.top_rgb;
                bot_reg  <= head.bot_rgb;
                atop_reg <= ptop[30:23];
                abot_reg <= pbot[30:23];
                cang_reg <= head.angle;
            end
            ST_ANG: begin
                if (cdone) begin
                    c_reg        <= cos_i;
                    s_reg        <= sin_i;
                    vsel_reg     <= '0;
                    seg_reg      <= '0;
                    aq_reg       <= '0;
                    ar_reg       <= RW'(SEGMENTS / 2);
                    segfirst_reg <= 1'b1;
                    cang_reg     <= '0;
                end
            end
            ST_SEG: begin
                if (cdone) begin
                    if (segfirst_reg) begin
                        c0_reg       <= cos_i;
                        s0_reg       <= sin_i;
                        segfirst_reg <= 1'b0;
                        aq_reg       <= aq_adv;
                        ar_reg       <= ar_adv;
                        cang_reg     <= aq_adv[15:0];
                    end else begin
                        c1_reg   <= cos_i;
                        s1_reg   <= sin_i;
                        vsel_reg <= '0;
                    end
                end
            end
            ST_MUL1: begin
                t1_reg <= c_reg * p;
                t2_reg <= s_reg * q;
                t3_reg <= s_reg * p;
                t4_reg <= c_reg * q;
            end
            ST_SUM: begin
                ex_reg <= 37'(t1_reg) - 37'(t2_reg);
                ey_reg <= 37'(t3_reg) + 37'(t4_reg);
            end
            ST_MUL2: begin
                m1x_reg <= $signed(ex_reg[36:18]) * mval;
                m2x_reg <= $signed({1'b0, ex_reg[17:0]}) * mval;
                m1y_reg <= $signed(ey_reg[36:18]) * mval;
                m2y_reg <= $signed({1'b0, ey_reg[17:0]}) * mval;
            end
            ST_FIN: begin
                tdata_reg <= {4'b0000, cnt_reg, (use_bot ? abot_reg : atop_reg),
                              rgb[7:0], rgb[15:8], rgb[23:16], vy, vx};
                tuser_reg <= opq_reg;
                tlast_reg <= vlast;
            end
            ST_OUT: begin
                if (m_tready && !vlast) begin
                    if (kind_reg == KIND_CIRCLE && vsel_reg == 3'd2) begin
                        c0_reg   <= c1_reg;
                        s0_reg   <= s1_reg;
                        seg_reg  <= seg_reg + 1'b1;
                        aq_reg   <= aq_adv;
                        ar_reg   <= ar_adv;
                        cang_reg <= aq_adv[15:0];
                    end else begin
                        vsel_reg <= vsel_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/sqct_checker.sv]
module sqct_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [sqct_pkg::OUT_DW-1:0] m_tdata,
    input logic                        m_tuser,
    input logic                        m_tlast
);
    import sqct_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("m_ payload changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[79:76] == 4'b0000)
        else $error("m_tdata pad bits set");

    a_vertex_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("vertex issued right after previous handoff");

endmodule

bind sprite_quad_circle_tessellator_top sqct_checker u_sqct_checker (.*);
